### hdl/salt_pkg.sv
// Package for the set-associative true-LRU tag directory.
// Holds sizes, operation and line-state codes, and the structs shared by top, ctrl and dpath.
// No dependencies.
package salt_pkg;

   localparam int SETS     = 32768;
   localparam int WAYS     = 8;
   localparam int TAG_BITS = 11;

   localparam int SET_BITS   = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int WAY_BITS   = $clog2(WAYS);
   localparam int AGE_BITS   = $clog2(WAYS);
   localparam int STATE_BITS = 3;
   localparam int FUNC_BITS  = 3;
   localparam int IDX_BITS   = 15;
   localparam int WSEL_BITS  = 3;
   localparam int TAGF_BITS  = 11;

   localparam int TAG_ROW_BITS  = WAYS * TAG_BITS;
   localparam int META_ROW_BITS = WAYS * (STATE_BITS + AGE_BITS);

   localparam logic [FUNC_BITS-1:0] FUNC_CLEAR   = 3'd0;
   localparam logic [FUNC_BITS-1:0] FUNC_LOOKUP  = 3'd1;
   localparam logic [FUNC_BITS-1:0] FUNC_TOUCH   = 3'd2;
   localparam logic [FUNC_BITS-1:0] FUNC_VICTIM  = 3'd3;
   localparam logic [FUNC_BITS-1:0] FUNC_INSTALL = 3'd4;

   localparam logic [STATE_BITS-1:0] LINE_INVALID  = 3'd0;
   localparam logic [STATE_BITS-1:0] LINE_MODIFIED = 3'd4;
   localparam logic [STATE_BITS-1:0] LINE_LAST     = 3'd4;

   typedef struct packed {
      logic [FUNC_BITS-1:0]  func;
      logic [IDX_BITS-1:0]   set_index;
      logic [WSEL_BITS-1:0]  way_sel;
      logic [TAGF_BITS-1:0]  tag;
      logic [STATE_BITS-1:0] line_state;
   } item_type;

   typedef struct packed {
      logic                  hit;
      logic [WSEL_BITS-1:0]  way;
      logic [STATE_BITS-1:0] state_out;
      logic                  writeback;
   } result_type;

   typedef struct packed {
      logic accept;
      logic exec;
      logic sweep;
   } cmd_type;

   typedef struct packed {
      logic can_load;
      logic sweep_last;
      logic req_clear;
   } status_type;

endpackage

### hdl/salt_if.sv
// Request and response channel interfaces of the tag directory.
// Depends on salt_pkg for field widths.
interface salt_req_if import salt_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [FUNC_BITS-1:0]  func;
   logic [IDX_BITS-1:0]   set_index;
   logic [WSEL_BITS-1:0]  way_sel;
   logic [TAGF_BITS-1:0]  tag;
   logic [STATE_BITS-1:0] line_state;

   modport source (output valid, func, set_index, way_sel, tag, line_state, input ready);
   modport sink   (input valid, func, set_index, way_sel, tag, line_state, output ready);
endinterface

interface salt_rsp_if import salt_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  hit;
   logic [WSEL_BITS-1:0]  way;
   logic [STATE_BITS-1:0] state_out;
   logic                  writeback;

   modport source (output valid, hit, way, state_out, writeback, input ready);
   modport sink   (input valid, hit, way, state_out, writeback, output ready);
endinterface

### hdl/set_assoc_lru_tag_directory.sv
// Tag directory with true-LRU ages. An accepted request beat reads its set row into the
// registered outputs of the set RAMs; the execute state, which waits until any earlier result
// is taken, then registers the result and writes the modified row back; only then is the next beat taken.
// A clear and a synchronous reset both start a sweep of all SETS sets (32768) that marks all lines
// invalid and all ages oldest, with req_bus.ready low; one waiting result does not stall intake.
// Depends on salt_pkg, salt_if, salt_ctrl and salt_dpath.
module set_assoc_lru_tag_directory import salt_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   salt_req_if.sink      req_bus,
   salt_rsp_if.source    rsp_bus
);

   cmd_type    cmd;
   status_type status;
   item_type   req_item;
   result_type rsp_result;
   logic       req_ready;
   logic       rsp_valid;

   assign req_item.func       = req_bus.func;
   assign req_item.set_index  = req_bus.set_index;
   assign req_item.way_sel    = req_bus.way_sel;
   assign req_item.tag        = req_bus.tag;
   assign req_item.line_state = req_bus.line_state;

   salt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   salt_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_item   (req_item),
      .cmd        (cmd),
      .status     (status),
      .rsp_ready  (rsp_bus.ready),
      .rsp_valid  (rsp_valid),
      .rsp_result (rsp_result)
   );

   assign req_bus.ready     = req_ready;
   assign rsp_bus.valid     = rsp_valid;
   assign rsp_bus.hit       = rsp_result.hit;
   assign rsp_bus.way       = rsp_result.way;
   assign rsp_bus.state_out = rsp_result.state_out;
   assign rsp_bus.writeback = rsp_result.writeback;

endmodule

### hdl/salt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module salt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/salt_ctrl.sv
// Controller of the tag directory: sweep, accept and execute sequencing.
// Depends on salt_pkg for the command and status structs.
module salt_ctrl import salt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [1:0] {
      S_SWEEP,
      S_IDLE,
      S_EXEC
   } state_type;

   state_type state_ff, state_in;
   logic      clr_pend_ff, clr_pend_in;

   always_comb begin
      state_in    = state_ff;
      clr_pend_in = clr_pend_ff;
      cmd         = '0;
      req_ready   = 1'b0;
      case (state_ff)
         S_SWEEP: begin
            cmd.sweep = 1'b1;
            if (status.sweep_last) begin
               state_in    = clr_pend_ff ? S_EXEC : S_IDLE;
               clr_pend_in = 1'b0;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (status.req_clear) begin
                  state_in    = S_SWEEP;
                  clr_pend_in = 1'b1;
               end else begin
                  state_in = S_EXEC;
               end
            end
         end
         S_EXEC: begin
            if (status.can_load) begin
               cmd.exec = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_SWEEP;
         clr_pend_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_pend_ff <= clr_pend_in;
      end
   end

endmodule

### hdl/salt_dpath.sv
// Datapath of the tag directory: item and result registers, set RAMs, LRU update logic.
// Depends on salt_pkg and salt_ram.
module salt_dpath import salt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  item_type   req_item,
   input  cmd_type    cmd,
   output status_type status,
   input  logic       rsp_ready,
   output logic       rsp_valid,
   output result_type rsp_result
);

   item_type   item_ff;
   result_type result_ff, result_in;
   logic       out_valid_ff;
   logic [SET_BITS-1:0] sweep_cnt_ff, sweep_cnt_in;
   logic       sweep_last;

   logic [TAG_ROW_BITS-1:0]  tag_row, tag_row_new;
   logic [META_ROW_BITS-1:0] meta_row, meta_row_new, meta_row_clr, meta_wr_data;
   logic                     meta_wr_en, tag_wr_en;
   logic [SET_BITS-1:0]      meta_wr_addr, item_set;

   logic [TAG_BITS-1:0]   tag_w   [WAYS];
   logic [STATE_BITS-1:0] st_w    [WAYS];
   logic [AGE_BITS-1:0]   age_w   [WAYS];
   logic [STATE_BITS-1:0] st_new  [WAYS];
   logic [AGE_BITS-1:0]   age_new [WAYS];

   logic                  way_ok;
   logic [WAY_BITS-1:0]   wsel;
   logic [AGE_BITS-1:0]   mine;
   logic [STATE_BITS-1:0] inst_state;
   logic                  hit_found, inv_found, old_found;
   logic [WSEL_BITS-1:0]  hit_way, inv_way, old_way, pick_way;
   logic [STATE_BITS-1:0] pick_state;

   assign item_set   = item_ff.set_index[SET_BITS-1:0];
   assign sweep_last = (sweep_cnt_ff == SET_BITS'(SETS - 1));
   assign way_ok     = (32'(item_ff.way_sel) < WAYS);
   assign wsel       = item_ff.way_sel[WAY_BITS-1:0];
   assign inst_state = (item_ff.line_state > LINE_LAST) ? LINE_INVALID : item_ff.line_state;

   always_comb begin
      for (int k = 0; k < WAYS; k++) begin
         tag_w[k] = tag_row[k*TAG_BITS +: TAG_BITS];
         st_w[k]  = meta_row[k*STATE_BITS +: STATE_BITS];
         age_w[k] = meta_row[WAYS*STATE_BITS + k*AGE_BITS +: AGE_BITS];
      end
   end

   always_comb begin
      mine = age_w[wsel];
      hit_found = 1'b0;
      inv_found = 1'b0;
      old_found = 1'b0;
      hit_way   = '0;
      inv_way   = '0;
      old_way   = '0;
      for (int k = 0; k < WAYS; k++) begin
         st_new[k]  = st_w[k];
         age_new[k] = age_w[k];
         if (!hit_found && st_w[k] != LINE_INVALID
             && tag_w[k] == item_ff.tag[TAG_BITS-1:0]) begin
            hit_found = 1'b1;
            hit_way   = WSEL_BITS'(k);
         end
         if (!inv_found && st_w[k] == LINE_INVALID) begin
            inv_found = 1'b1;
            inv_way   = WSEL_BITS'(k);
         end
         if (!old_found && age_w[k] == AGE_BITS'(WAYS - 1)) begin
            old_found = 1'b1;
            old_way   = WSEL_BITS'(k);
         end
         if (item_ff.func == FUNC_TOUCH && mine != '0 && age_w[k] < mine) begin
            age_new[k] = age_w[k] + AGE_BITS'(1);
         end
      end
      if (item_ff.func == FUNC_TOUCH && mine != '0) begin
         age_new[wsel] = '0;
      end
      if (item_ff.func == FUNC_INSTALL) begin
         st_new[wsel] = inst_state;
      end
      pick_way   = inv_found ? inv_way : (old_found ? old_way : '0);
      pick_state = st_w[pick_way[WAY_BITS-1:0]];
   end

   always_comb begin
      tag_row_new = tag_row;
      tag_row_new[wsel*TAG_BITS +: TAG_BITS] = item_ff.tag[TAG_BITS-1:0];
      for (int k = 0; k < WAYS; k++) begin
         meta_row_new[k*STATE_BITS +: STATE_BITS]              = st_new[k];
         meta_row_new[WAYS*STATE_BITS + k*AGE_BITS +: AGE_BITS] = age_new[k];
         meta_row_clr[k*STATE_BITS +: STATE_BITS]              = LINE_INVALID;
         meta_row_clr[WAYS*STATE_BITS + k*AGE_BITS +: AGE_BITS] = AGE_BITS'(WAYS - 1);
      end
   end

   always_comb begin
      result_in = '0;
      case (item_ff.func)
         FUNC_LOOKUP: begin
            if (hit_found) begin
               result_in.hit       = 1'b1;
               result_in.way       = hit_way;
               result_in.state_out = st_w[hit_way[WAY_BITS-1:0]];
            end
         end
         FUNC_VICTIM: begin
            result_in.way       = pick_way;
            result_in.state_out = pick_state;
            result_in.writeback = (pick_state == LINE_MODIFIED);
         end
         default: begin
            result_in = '0;
         end
      endcase
   end

   assign meta_wr_en   = cmd.sweep
                       || (cmd.exec && way_ok
                           && (item_ff.func == FUNC_TOUCH || item_ff.func == FUNC_INSTALL));
   assign meta_wr_addr = cmd.sweep ? sweep_cnt_ff : item_set;
   assign meta_wr_data = cmd.sweep ? meta_row_clr : meta_row_new;
   assign tag_wr_en    = cmd.exec && way_ok && (item_ff.func == FUNC_INSTALL);

   salt_ram #(
      .WIDTH (TAG_ROW_BITS),
      .DEPTH (SETS)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (tag_wr_en),
      .wr_addr (item_set),
      .wr_data (tag_row_new),
      .rd_en   (cmd.accept),
      .rd_addr (req_item.set_index[SET_BITS-1:0]),
      .rd_data (tag_row)
   );

   salt_ram #(
      .WIDTH (META_ROW_BITS),
      .DEPTH (SETS)
   ) u_meta_ram (
      .clock   (clock),
      .wr_en   (meta_wr_en),
      .wr_addr (meta_wr_addr),
      .wr_data (meta_wr_data),
      .rd_en   (cmd.accept),
      .rd_addr (req_item.set_index[SET_BITS-1:0]),
      .rd_data (meta_row)
   );

   assign sweep_cnt_in = sweep_last ? '0 : sweep_cnt_ff + SET_BITS'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_cnt_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.sweep) begin
            sweep_cnt_ff <= sweep_cnt_in;
         end
         if (cmd.exec) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         item_ff <= req_item;
      end
      if (cmd.exec) begin
         result_ff <= result_in;
      end
   end

   assign status.can_load   = !out_valid_ff || rsp_ready;
   assign status.sweep_last = sweep_last;
   assign status.req_clear  = (req_item.func == FUNC_CLEAR);

   assign rsp_valid  = out_valid_ff;
   assign rsp_result = result_ff;

endmodule

### test/testbench.sv
// Self-checking testbench for the set-associative true-LRU tag directory.
// Drives lookup, touch, victim, install, clear and undefined-code beats, predicts
// every response, compares it field by field; needs salt_pkg, salt_if, top level.
module testbench;
   import salt_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LINES         = SETS * WAYS;
   localparam int WATCHDOG_MAX  = 150000;
   localparam int LONG_HOLD     = 400;
   localparam int HOLD_AT       = 500;
   localparam int DRAIN_AT      = 1100;
   localparam int RANDOM_BEATS  = 2000;
   localparam int TAIL_CYCLES   = 20;
   localparam int HOT_SET_COUNT = 6;

   typedef struct {
      item_type    beat;
      int unsigned gap;
      bit          drain;
   } queued_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   salt_req_if req_bus ();
   salt_rsp_if rsp_bus ();

   set_assoc_lru_tag_directory DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // directory shadow
   logic [TAG_BITS-1:0]   line_tag   [LINES];
   logic [STATE_BITS-1:0] line_coh   [LINES];
   logic [AGE_BITS-1:0]   line_age   [LINES];

   queued_beat_type beats_to_send [$];
   result_type      expected_results [$];
   item_type        cur_beat;

   int unsigned gap_left       = 0;
   int unsigned beats_queued   = 0;
   int unsigned beats_accepted = 0;
   int unsigned results_seen   = 0;
   int unsigned rsp_wait       = 0;
   int unsigned idle_cycles    = 0;
   int unsigned mismatches     = 0;
   int unsigned hot_sets [HOT_SET_COUNT];
   bit          gapless        = 1'b0;

   initial begin
      req_bus.valid      = 1'b0;
      req_bus.func       = FUNC_LOOKUP;
      req_bus.set_index  = '0;
      req_bus.way_sel    = '0;
      req_bus.tag        = '0;
      req_bus.line_state = LINE_INVALID;
      rsp_bus.ready      = 1'b0;
   end

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic void wipe_directory();
      for (int n = 0; n < LINES; n++) begin
         line_coh[n] = LINE_INVALID;
         line_age[n] = AGE_BITS'(WAYS - 1);
      end
   endfunction

   function automatic result_type predict_directory(item_type b);
      result_type          r;
      int unsigned         base;
      int unsigned         pick;
      logic [AGE_BITS-1:0] mine;
      bit                  found;
      r     = '0;
      found = 1'b0;
      pick  = 0;
      base  = (int'(b.set_index) % SETS) * WAYS;
      case (b.func)
         FUNC_CLEAR: wipe_directory();
         FUNC_LOOKUP: begin
            for (int k = 0; k < WAYS; k++) begin
               if (!found && line_coh[base+k] != LINE_INVALID &&
                   line_tag[base+k] == b.tag[TAG_BITS-1:0]) begin
                  found       = 1'b1;
                  r.hit       = 1'b1;
                  r.way       = WSEL_BITS'(k);
                  r.state_out = line_coh[base+k];
               end
            end
         end
         FUNC_TOUCH: begin
            if (b.way_sel < WAYS) begin
               mine = line_age[base+b.way_sel];
               if (mine != 0) begin
                  for (int k = 0; k < WAYS; k++) begin
                     if (line_age[base+k] < mine) line_age[base+k] = line_age[base+k] + 1'b1;
                  end
                  line_age[base+b.way_sel] = '0;
               end
            end
         end
         FUNC_VICTIM: begin
            for (int k = 0; k < WAYS; k++) begin
               if (!found && line_coh[base+k] == LINE_INVALID) begin
                  found = 1'b1;
                  pick  = k;
               end
            end
            for (int k = 0; k < WAYS; k++) begin
               if (!found && line_age[base+k] == AGE_BITS'(WAYS - 1)) begin
                  found = 1'b1;
                  pick  = k;
               end
            end
            r.way       = WSEL_BITS'(pick);
            r.state_out = line_coh[base+pick];
            r.writeback = (line_coh[base+pick] == LINE_MODIFIED);
         end
         FUNC_INSTALL: begin
            if (b.way_sel < WAYS) begin
               line_tag[base+b.way_sel] = b.tag[TAG_BITS-1:0];
               line_coh[base+b.way_sel] = (b.line_state > LINE_LAST) ? LINE_INVALID
                                                                      : b.line_state;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic push_beat(logic [FUNC_BITS-1:0] f, int unsigned s, int unsigned w,
                            int unsigned t, int unsigned st, bit drain = 1'b0);
      queued_beat_type q;
      q.beat.func       = f;
      q.beat.set_index  = IDX_BITS'(s);
      q.beat.way_sel    = WSEL_BITS'(w);
      q.beat.tag        = TAGF_BITS'(t);
      q.beat.line_state = STATE_BITS'(st);
      q.gap             = gapless ? 0 : $urandom_range(0, 10);
      q.drain           = drain;
      beats_to_send.push_back(q);
      beats_queued++;
   endtask

   function automatic int unsigned pick_hot_set();
      return hot_sets[$urandom_range(0, HOT_SET_COUNT - 1)];
   endfunction

   task automatic fill_directed();
      push_beat(FUNC_LOOKUP, 0, 0, 0, 0);
      push_beat(FUNC_VICTIM, 0, 7, 2047, 7);
      for (int w = 0; w < WAYS; w++) begin
         push_beat(FUNC_INSTALL, SETS - 1, w, (w == 0) ? 2047 : w - 1, (w % 4) + 1);
      end
      push_beat(FUNC_LOOKUP, SETS - 1, 0, 2047, 0);
      push_beat(FUNC_LOOKUP, SETS - 1, 0, 0, 0);
      push_beat(FUNC_VICTIM, SETS - 1, 0, 0, 0);
      push_beat(FUNC_TOUCH, SETS - 1, 3, 0, 0);
      push_beat(FUNC_VICTIM, SETS - 1, 0, 0, 0);
      push_beat(FUNC_TOUCH, SETS - 1, 3, 0, 0);
      push_beat(FUNC_INSTALL, SETS - 1, 3, 1234, 5);
      push_beat(FUNC_VICTIM, SETS - 1, 0, 0, 0);
      push_beat(FUNC_INSTALL, SETS - 1, 5, 77, 7);
      push_beat(3'd5, SETS - 1, 7, 2047, 7);
      push_beat(3'd6, 0, 0, 0, 0);
      push_beat(3'd7, 12345, 5, 1000, 3);
      push_beat(FUNC_CLEAR, 0, 0, 0, 0);
      push_beat(FUNC_LOOKUP, SETS - 1, 0, 2047, 0);
      push_beat(FUNC_VICTIM, SETS - 1, 0, 0, 0);
   endtask

   task automatic fill_random();
      int unsigned s;
      int unsigned t;
      int unsigned w;
      int unsigned kind;
      int unsigned next_clear;
      int unsigned fill_tags [WAYS];
      bit          drain_pushed;
      drain_pushed = 1'b0;
      next_clear = beats_queued + 700;
      while (beats_queued < RANDOM_BEATS) begin
         gapless = ((beats_queued / 150) % 4) == 2;
         kind    = $urandom_range(0, 99);
         s       = pick_hot_set();
         if (kind < 40) begin
            t = $urandom_range(0, 2047);
            w = $urandom_range(0, WAYS - 1);
            push_beat(FUNC_LOOKUP, s, $urandom_range(0, 7), t, $urandom_range(0, 7));
            push_beat(FUNC_VICTIM, s, $urandom_range(0, 7), t, $urandom_range(0, 7));
            push_beat(FUNC_INSTALL, s, w, t,
                      ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7)
                                                  : $urandom_range(1, 4));
            push_beat(FUNC_TOUCH, s, w, $urandom_range(0, 2047), $urandom_range(0, 7));
            push_beat(FUNC_LOOKUP, s, $urandom_range(0, 7), t, $urandom_range(0, 7));
         end else if (kind < 55) begin
            for (int k = 0; k < WAYS; k++) begin
               fill_tags[k] = $urandom_range(0, 2047);
               push_beat(FUNC_INSTALL, s, k, fill_tags[k], $urandom_range(1, 4));
            end
            repeat ($urandom_range(0, 8)) push_beat(FUNC_TOUCH, s, $urandom_range(0, 7), 0, 0);
            push_beat(FUNC_VICTIM, s, 0, 0, 0);
            push_beat(FUNC_LOOKUP, s, 0, fill_tags[$urandom_range(0, WAYS - 1)], 0);
         end else if (kind < 90) begin
            push_beat(FUNC_BITS'($urandom_range(1, 7)), s, $urandom_range(0, 7),
                      $urandom_range(0, 2047), $urandom_range(0, 7));
         end else begin
            push_beat(FUNC_BITS'($urandom_range(1, 7)), $urandom_range(0, 32767),
                      $urandom_range(0, 7), $urandom_range(0, 2047), $urandom_range(0, 7));
         end
         if (beats_queued >= next_clear) begin
            push_beat(FUNC_CLEAR, $urandom_range(0, 32767), $urandom_range(0, 7),
                      $urandom_range(0, 2047), $urandom_range(0, 7));
            next_clear = next_clear + 700;
         end
         if (!drain_pushed && beats_queued >= DRAIN_AT) begin
            push_beat(FUNC_LOOKUP, s, 0, $urandom_range(0, 2047), 0, 1'b1);
            drain_pushed = 1'b1;
         end
      end
   endtask

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : driver
      bit              offer;
      queued_beat_type next_q;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         offer = req_bus.valid;
         if (req_bus.valid && req_bus.ready) begin
            expected_results.push_back(predict_directory(cur_beat));
            beats_accepted++;
            offer = 1'b0;
         end
         if (!offer && beats_to_send.size() > 0 &&
             !(beats_to_send[0].drain && expected_results.size() > 0)) begin
            if (gap_left < beats_to_send[0].gap) begin
               gap_left++;
            end else begin
               next_q   = beats_to_send.pop_front();
               cur_beat = next_q.beat;
               gap_left = 0;
               offer    = 1'b1;
               req_bus.func       <= cur_beat.func;
               req_bus.set_index  <= cur_beat.set_index;
               req_bus.way_sel    <= cur_beat.way_sel;
               req_bus.tag        <= cur_beat.tag;
               req_bus.line_state <= cur_beat.line_state;
            end
         end
         req_bus.valid <= offer;
      end
   end

   always @(posedge clock) begin : monitor
      result_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_results.size() == 0) begin
               $error("response beat with no request outstanding");
               mismatches++;
            end else begin
               want = expected_results.pop_front();
               check_field("hit", want.hit, rsp_bus.hit);
               check_field("way", want.way, rsp_bus.way);
               check_field("state_out", want.state_out, rsp_bus.state_out);
               check_field("writeback", want.writeback, rsp_bus.writeback);
            end
            results_seen++;
            rsp_wait = ((results_seen / 64) % 2 == 1) ? 0 : $urandom_range(0, 10);
            if (results_seen == HOLD_AT) rsp_wait = LONG_HOLD;
         end
         if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_MAX) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      wipe_directory();
      hot_sets[0] = 0;
      hot_sets[1] = SETS - 1;
      for (int k = 2; k < HOT_SET_COUNT; k++) hot_sets[k] = $urandom_range(0, SETS - 1);
      fill_directed();
      fill_random();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      while (beats_accepted < beats_queued) @(posedge clock);
      while (expected_results.size() > 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_results.size() != 0) begin
         $error("responses still outstanding at end of run");
         mismatches++;
      end
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
